[hw/rtl/tmn_pkg.sv]
`default_nettype none

package tmn_pkg;

  localparam int unsigned TicketW = 32;
  localparam int unsigned IdW     = 8;
  localparam int unsigned FracW   = 10;
  localparam int unsigned KindW   = 2;
  localparam int unsigned ActW    = 2;

  localparam logic [KindW-1:0] KIND_REQUEST = 2'd0;
  localparam logic [KindW-1:0] KIND_REPLY   = 2'd1;
  localparam logic [KindW-1:0] KIND_WANT    = 2'd2;
  localparam logic [KindW-1:0] KIND_RELEASE = 2'd3;

  localparam logic [ActW-1:0] ACT_REPLY = 2'd0;
  localparam logic [ActW-1:0] ACT_BCAST = 2'd1;
  localparam logic [ActW-1:0] ACT_ENTER = 2'd2;

  typedef struct packed {
    logic accept;
    logic drain_step;
  } cmd_t;

  typedef struct packed {
    logic out_free;
    logic is_release;
    logic defer_empty;
    logic drain_last;
  } sts_t;

endpackage

`default_nettype wire

[hw/rtl/tmn_ctrl.sv]
`default_nettype none

module tmn_ctrl (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         in_valid_i,
  output logic              in_ready_o,
  input  wire tmn_pkg::sts_t sts_i,
  output tmn_pkg::cmd_t     cmd_o
);

  typedef enum logic {
    ST_IDLE,
    ST_DRAIN
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    in_ready_o        = 1'b0;
    cmd_o.accept      = 1'b0;
    cmd_o.drain_step  = 1'b0;
    state_d           = state_q;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o   = sts_i.out_free;
        cmd_o.accept = in_valid_i && sts_i.out_free;
        if (cmd_o.accept && sts_i.is_release && !sts_i.defer_empty) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        cmd_o.drain_step = sts_i.out_free;
        if (sts_i.out_free && sts_i.drain_last) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/tmn_dpath.sv]
`default_nettype none

module tmn_dpath #(
  parameter int unsigned NUM_PEERS = 2
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              cfg_wr_en_i,
  input  wire logic [tmn_pkg::IdW-1:0]           cfg_wr_data_i,
  input  wire logic [tmn_pkg::KindW-1:0]         kind_i,
  input  wire logic [tmn_pkg::TicketW-1:0]       peer_ticket_i,
  input  wire logic [tmn_pkg::IdW-1:0]           peer_id_i,
  input  wire logic [tmn_pkg::FracW-1:0]         random_fraction_i,
  input  wire tmn_pkg::cmd_t                     cmd_i,
  output tmn_pkg::sts_t                          sts_o,
  output logic                                   out_valid_o,
  input  wire logic                              out_ready_i,
  output logic [tmn_pkg::ActW-1:0]               action_o,
  output logic [tmn_pkg::IdW-1:0]                dest_id_o,
  output logic [tmn_pkg::TicketW-1:0]            ticket_out_o,
  output logic                                   last_o
);

  localparam int unsigned CntW = $clog2(NUM_PEERS + 1);
  localparam int unsigned IdxW = (NUM_PEERS > 1) ? $clog2(NUM_PEERS) : 1;
  localparam logic [CntW-1:0] Peers = CntW'(NUM_PEERS);

  logic [tmn_pkg::IdW-1:0]     own_id_q;
  logic                        wanting_q, wanting_d;
  logic [tmn_pkg::TicketW-1:0] own_ticket_q, own_ticket_d;
  logic [tmn_pkg::TicketW-1:0] max_seen_q, max_seen_d;
  logic [CntW-1:0]             reply_cnt_q, reply_cnt_d;
  logic [CntW-1:0]             defer_cnt_q, defer_cnt_d;
  logic [IdxW-1:0]             drain_idx_q, drain_idx_d;
  logic [tmn_pkg::IdW-1:0]     defer_ids_q [NUM_PEERS];

  logic                        out_valid_q, out_valid_d;
  logic [tmn_pkg::ActW-1:0]    action_q, action_d;
  logic [tmn_pkg::IdW-1:0]     dest_id_q, dest_id_d;
  logic [tmn_pkg::TicketW-1:0] ticket_q, ticket_d;
  logic                        last_q, last_d;

  logic                        reply_now;
  logic                        defer_wr;
  logic [CntW-1:0]             reply_inc;
  logic [tmn_pkg::TicketW:0]   ticket_sum;
  logic                        drain_last;

  assign reply_now = !wanting_q || (own_ticket_q > peer_ticket_i) ||
                     ((own_ticket_q == peer_ticket_i) && (own_id_q > peer_id_i));
  assign reply_inc  = reply_cnt_q + CntW'(1);
  assign ticket_sum = {1'b0, max_seen_q} +
                      {{(tmn_pkg::TicketW + 1 - tmn_pkg::FracW){1'b0}}, random_fraction_i};
  assign drain_last = ({{(CntW - IdxW){1'b0}}, drain_idx_q} == (defer_cnt_q - CntW'(1)));

  assign sts_o.out_free    = !out_valid_q || out_ready_i;
  assign sts_o.is_release  = (kind_i == tmn_pkg::KIND_RELEASE);
  assign sts_o.defer_empty = (defer_cnt_q == '0);
  assign sts_o.drain_last  = drain_last;

  always_comb begin
    wanting_d    = wanting_q;
    own_ticket_d = own_ticket_q;
    max_seen_d   = max_seen_q;
    reply_cnt_d  = reply_cnt_q;
    defer_cnt_d  = defer_cnt_q;
    drain_idx_d  = drain_idx_q;
    defer_wr     = 1'b0;
    out_valid_d  = out_valid_q && !out_ready_i;
    action_d     = action_q;
    dest_id_d    = dest_id_q;
    ticket_d     = ticket_q;
    last_d       = last_q;

    if (cmd_i.accept) begin
      case (kind_i)
        tmn_pkg::KIND_REQUEST: begin
          if (reply_now) begin
            if (peer_ticket_i > max_seen_q) begin
              max_seen_d = peer_ticket_i;
            end
            out_valid_d = 1'b1;
            action_d    = tmn_pkg::ACT_REPLY;
            dest_id_d   = peer_id_i;
            ticket_d    = '0;
            last_d      = 1'b1;
          end else if (defer_cnt_q < Peers) begin
            defer_wr    = 1'b1;
            defer_cnt_d = defer_cnt_q + CntW'(1);
          end
        end
        tmn_pkg::KIND_REPLY: begin
          if (reply_inc >= Peers) begin
            reply_cnt_d = '0;
            out_valid_d = 1'b1;
            action_d    = tmn_pkg::ACT_ENTER;
            dest_id_d   = '0;
            ticket_d    = '0;
            last_d      = 1'b1;
          end else begin
            reply_cnt_d = reply_inc;
          end
        end
        tmn_pkg::KIND_WANT: begin
          own_ticket_d = ticket_sum[tmn_pkg::TicketW] ? '1 : ticket_sum[tmn_pkg::TicketW-1:0];
          wanting_d    = 1'b1;
          out_valid_d  = 1'b1;
          action_d     = tmn_pkg::ACT_BCAST;
          dest_id_d    = '0;
          ticket_d     = own_ticket_d;
          last_d       = 1'b1;
        end
        default: begin
          wanting_d   = 1'b0;
          drain_idx_d = '0;
        end
      endcase
    end

    if (cmd_i.drain_step) begin
      out_valid_d = 1'b1;
      action_d    = tmn_pkg::ACT_REPLY;
      dest_id_d   = defer_ids_q[drain_idx_q];
      ticket_d    = '0;
      last_d      = drain_last;
      if (drain_last) begin
        defer_cnt_d = '0;
        drain_idx_d = '0;
      end else begin
        drain_idx_d = drain_idx_q + IdxW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      own_id_q     <= '0;
      wanting_q    <= 1'b0;
      own_ticket_q <= '0;
      max_seen_q   <= '0;
      reply_cnt_q  <= '0;
      defer_cnt_q  <= '0;
      drain_idx_q  <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_wr_en_i) begin
        own_id_q <= cfg_wr_data_i;
      end
      wanting_q    <= wanting_d;
      own_ticket_q <= own_ticket_d;
      max_seen_q   <= max_seen_d;
      reply_cnt_q  <= reply_cnt_d;
      defer_cnt_q  <= defer_cnt_d;
      drain_idx_q  <= drain_idx_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    action_q  <= action_d;
    dest_id_q <= dest_id_d;
    ticket_q  <= ticket_d;
    last_q    <= last_d;
    if (defer_wr) begin
      defer_ids_q[defer_cnt_q[IdxW-1:0]] <= peer_id_i;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign action_o     = action_q;
  assign dest_id_o    = dest_id_q;
  assign ticket_out_o = ticket_q;
  assign last_o       = last_q;

endmodule

`default_nettype wire

[hw/rtl/ticket_mutex_node.sv]
// One node of ticket-based distributed mutual exclusion.
// Input stream: s_axis_tuser carries the event kind (peer request, peer reply,
// local want, local release) and s_axis_tdata carries the peer ticket, peer id
// and random fraction. Output stream: m_axis_tuser carries the action (reply,
// broadcast, enter), m_axis_tdata the destination id and ticket, and
// m_axis_tlast marks the final result caused by one input item.
// The node id is written through cfg_wr_en_i and cfg_wr_data_i; the user must
// do so only while idle, the block itself does not enforce this. A result
// appears in the cycle after its item is accepted. A release with deferred
// peers emits one reply per deferred peer whenever the output register is free,
// and the next item is taken after the last of them.
// Throughput is set by the single output register: one item or one deferred
// reply per cycle while the receiver keeps m_axis_tready high.
// When the receiver stalls, the output register holds its result and no new
// item is accepted until that result is taken.
// Reset clears the wanting flag, both tickets, the reply and deferred counts
// and the node id, and empties the output register.
`default_nettype none

module ticket_mutex_node #(
  parameter int unsigned NUM_PEERS = 2
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_wr_en_i,
  input  wire logic [7:0]  cfg_wr_data_i,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [55:0] s_axis_tdata,   // peer_ticket, peer_id, random_fraction, zero pad
  input  wire logic [1:0]  s_axis_tuser,   // kind
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [39:0]      m_axis_tdata,   // dest_id, ticket_out
  output logic [1:0]       m_axis_tuser,   // action
  output logic             m_axis_tlast
);

  tmn_pkg::cmd_t ctrl_cmd;
  tmn_pkg::sts_t dp_sts;

  tmn_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (dp_sts),
    .cmd_o      (ctrl_cmd)
  );

  tmn_dpath #(
    .NUM_PEERS (NUM_PEERS)
  ) u_dpath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_wr_en_i       (cfg_wr_en_i),
    .cfg_wr_data_i     (cfg_wr_data_i),
    .kind_i            (s_axis_tuser),
    .peer_ticket_i     (s_axis_tdata[31:0]),
    .peer_id_i         (s_axis_tdata[39:32]),
    .random_fraction_i (s_axis_tdata[49:40]),
    .cmd_i             (ctrl_cmd),
    .sts_o             (dp_sts),
    .out_valid_o       (m_axis_tvalid),
    .out_ready_i       (m_axis_tready),
    .action_o          (m_axis_tuser),
    .dest_id_o         (m_axis_tdata[7:0]),
    .ticket_out_o      (m_axis_tdata[39:8]),
    .last_o            (m_axis_tlast)
  );

`ifndef NO_ASSERTIONS
  a_no_accept_in_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_cmd.drain_step |-> !ctrl_cmd.accept)
    else $error("item accepted while deferred replies drain");

  a_drain_needs_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_cmd.drain_step |-> (!m_axis_tvalid || m_axis_tready))
    else $error("deferred reply overwrote a pending result");

  a_release_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl_cmd.accept && dp_sts.is_release && !dp_sts.defer_empty) |=> !s_axis_tready)
    else $error("input ready right after a release with deferred peers");
`endif

endmodule

`default_nettype wire
